>>> rtl/mtflru_pkg.sv
// Shared types and constants for the move-to-front LRU cache.
// Used by the controller, the datapath, the top level and the checker.
package mtflru_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int NUM_W         = 24;
  localparam int GEN_W         = 16;
  localparam int HANDLE_W      = 16;

  typedef struct packed {
    logic [NUM_W-1:0]    obj_num;
    logic [GEN_W-1:0]    obj_gen;
    logic [HANDLE_W-1:0] new_handle;
  } lookup_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic                evicted_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [NUM_W-1:0]    num;
    logic [GEN_W-1:0]    gen;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic load;
    logic update;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage

>>> rtl/mtflru_ctrl.sv
// Controller for the move-to-front LRU cache: two-state sequencer.
// Depends on mtflru_pkg for the state and command types.
module mtflru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output mtflru_pkg::cmd_t  cmd
);

  mtflru_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtflru_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.update;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    unique case (state)
      mtflru_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = mtflru_pkg::ST_UPDATE;
        end
      end
      mtflru_pkg::ST_UPDATE: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
        state_next = mtflru_pkg::ST_IDLE;
      end
      default: state_next = mtflru_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/mtflru_dp.sv
// Datapath for the move-to-front LRU cache: entry chain, key compare,
// move-to-front shift and result register. Depends on mtflru_pkg.
module mtflru_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  mtflru_pkg::cmd_t      cmd,
  input  mtflru_pkg::lookup_t   lookup,
  output mtflru_pkg::result_t   result
);

  localparam int N = mtflru_pkg::CACHE_ENTRIES;

  mtflru_pkg::entry_t  entries [N];
  mtflru_pkg::lookup_t key;
  logic [N-1:0]        match_q;
  logic [N-1:0]        match_now;
  logic [N-1:0]        first;
  logic [N-1:0]        shift_mask;
  logic                hit;
  mtflru_pkg::entry_t  sel_entry;
  mtflru_pkg::entry_t  front_next;

  // Every cell compares against the key presented with start; the
  // entries are stable in the idle cycle, so the vector is registered.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_now[i] = entries[i].valid &&
                     (entries[i].num == lookup.obj_num) &&
                     (entries[i].gen == lookup.obj_gen);
    end
  end

  // Isolate the match nearest the front and mark every cell at or
  // ahead of it; on a miss the whole chain shifts.
  always_comb begin
    first      = match_q & (~match_q + 1'b1);
    hit        = |match_q;
    shift_mask = hit ? (first | (first - 1'b1)) : '1;
    sel_entry  = '0;
    for (int i = 0; i < N; i++) begin
      sel_entry = sel_entry | (first[i] ? entries[i] : '0);
    end
    if (hit) begin
      front_next = sel_entry;
    end else begin
      front_next.valid  = 1'b1;
      front_next.num    = key.obj_num;
      front_next.gen    = key.obj_gen;
      front_next.handle = key.new_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= lookup;
      match_q <= match_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        entries[i].valid <= 1'b0;
      end
    end else if (cmd.update) begin
      entries[0] <= front_next;
      for (int i = 1; i < N; i++) begin
        if (shift_mask[i]) begin
          entries[i] <= entries[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.hit            <= hit;
      result.handle         <= hit ? sel_entry.handle : key.new_handle;
      result.evicted_valid  <= !hit && entries[N-1].valid;
      result.evicted_handle <= (!hit && entries[N-1].valid) ?
                               entries[N-1].handle : '0;
    end
  end

endmodule

>>> rtl/move_to_front_lru_cache.sv
// Top level of the move-to-front LRU cache.
// Depends on mtflru_pkg, mtflru_ctrl and mtflru_dp.
//
// Usage:
//   A lookup is transferred at a rising edge where start is high and busy
//   is low; the lookup struct carries the key (obj_num, obj_gen) and the
//   handle to install on a miss. All cells compare the key in that same
//   cycle and the match vector is registered.
//   The next cycle (busy high) moves the first matching entry, or the new
//   key on a miss, to the front and shifts the entries ahead of it back.
//   The result struct and done are registered from the shift command; the
//   result is then shown for exactly one cycle with done high, and a miss
//   that pushes out a valid last entry reports its handle in evicted_handle.
//   No new lookup is taken while busy is high in the shift cycle; a new
//   lookup may be transferred in the cycle in which done is high.
//   The receiver cannot stall: a result not taken in its done cycle is
//   kept only until the next lookup overwrites it.
//   A synchronous reset invalidates every entry at once, so the cache is
//   empty after reset and no clearing pass is needed.
module move_to_front_lru_cache (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mtflru_pkg::lookup_t  lookup,
  output logic                 busy,
  output logic                 done,
  output mtflru_pkg::result_t  result
);

  mtflru_pkg::cmd_t cmd;

  mtflru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mtflru_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .lookup (lookup),
    .result (result)
  );

endmodule

>>> rtl/mtflru_chk.sv
// Port-level checker for the move-to-front LRU cache, bound to the top.
// Depends on mtflru_pkg for the lookup and result types.
module mtflru_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input mtflru_pkg::lookup_t  lookup,
  input logic                 busy,
  input logic                 done,
  input mtflru_pkg::result_t  result
);

  // A transfer makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");

  // The work ends with its busy cycle; the result then appears with done high and busy low.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy)) else $error("busy cycle not followed by done");

  // A result only follows a busy cycle.
  a_done_past: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without prior busy cycle");

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |-> (!result.evicted_valid && result.evicted_handle == '0))
    else $error("hit reported an eviction");

  // Without a transfer the block stays idle.
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy) else $error("busy without a transfer");

endmodule

bind move_to_front_lru_cache mtflru_chk u_chk (.*);
